// ----- design/cdt_pkg.sv -----
`default_nettype none

package cdt_pkg;

    // Field widths
    localparam int unsigned MS_W   = 31;
    localparam int unsigned TICK_W = 22;

    // Default game ticks per second
    localparam int unsigned TICK_RATE_DEF = 30;

    // Largest millisecond count
    localparam logic [MS_W-1:0] MS_MAX = '1;

    // Request kinds
    typedef enum logic [1:0]
    {
        ACT_SET     = 2'd0,
        ACT_STOP    = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_UPDATE  = 2'd3
    } action_t;

    // Request as it arrives
    typedef struct packed
    {
        action_t             action;
        logic [MS_W-1:0]     load_ms;
        logic                start_now;
        logic [TICK_W-1:0]   game_tick;
    } req_t;

    // Request with the tick count turned into milliseconds
    typedef struct packed
    {
        action_t             action;
        logic [MS_W-1:0]     load_ms;
        logic                start_now;
        logic [MS_W-1:0]     now_ms;
    } timed_t;

    // Timer state after one request
    typedef struct packed
    {
        logic [MS_W-1:0]     remaining_ms;
        logic                running;
    } status_t;

    // Full readout
    typedef struct packed
    {
        logic [MS_W-1:0]     remaining_ms;
        logic                running;
        logic [3:0]          ms_units_digit;
        logic [3:0]          hundredths_digit;
        logic [3:0]          tenths_digit;
        logic [3:0]          seconds_units_digit;
        logic [2:0]          seconds_tens_digit;
        logic [3:0]          minutes_units_digit;
        logic [2:0]          minutes_tens_digit;
        logic [3:0]          hours_units_digit;
        logic [3:0]          hours_tens_digit;
    } result_t;

endpackage

`default_nettype wire

// ----- design/cdt_conv.sv -----
`default_nettype none

module cdt_conv
#(
    parameter int unsigned TICK_RATE = cdt_pkg::TICK_RATE_DEF
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire cdt_pkg::req_t   in_req,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output cdt_pkg::timed_t      out_timed
);
    import cdt_pkg::*;

    // ticks * 1000 / TICK_RATE as a multiply by a rounded-up reciprocal;
    // the shift leaves enough guard bits for every 22-bit tick count
    localparam int unsigned RATE_LOG = $clog2(TICK_RATE);
    localparam int unsigned SHIFT    = TICK_W + RATE_LOG;
    localparam int unsigned PROD_W   = SHIFT + 32;
    localparam logic [63:0] RECIP    =
        (((64'd1 << SHIFT) * 64'd1000) + 64'(TICK_RATE) - 64'd1) / 64'(TICK_RATE);

    logic           in_valid_reg;
    logic           out_valid_reg;
    req_t           req_reg;
    timed_t         timed_reg;
    timed_t         timed_next;
    logic           out_stage_ready;
    logic [PROD_W-1:0] prod;
    logic [31:0]    quot;

    // Stage handshake
    assign out_stage_ready = !out_valid_reg || out_ready;
    assign in_ready        = !in_valid_reg || out_stage_ready;
    assign out_valid       = out_valid_reg;
    assign out_timed       = timed_reg;

    // Convert ticks to milliseconds, saturate at the 31-bit limit
    always_comb
    begin
        prod                  = PROD_W'(req_reg.game_tick) * RECIP[PROD_W-1:0];
        quot                  = prod[SHIFT +: 32];
        timed_next.action     = req_reg.action;
        timed_next.load_ms    = req_reg.load_ms;
        timed_next.start_now  = req_reg.start_now;
        timed_next.now_ms     = quot[31] ? MS_MAX : quot[MS_W-1:0];
    end

    // Advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_stage_ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            req_reg <= in_req;
        end
        if (out_stage_ready)
        begin
            timed_reg <= timed_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/cdt_state.sv -----
`default_nettype none

module cdt_state
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire cdt_pkg::timed_t  in_timed,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output cdt_pkg::status_t      out_status
);
    import cdt_pkg::*;

    logic [MS_W-1:0] count_reg;
    logic [MS_W-1:0] count_next;
    logic            run_reg;
    logic            run_next;
    logic [MS_W-1:0] last_reg;
    logic [MS_W-1:0] last_next;
    logic            out_valid_reg;
    logic [MS_W-1:0] elapsed;
    logic            take;

    assign in_ready  = !out_valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign elapsed   = in_timed.now_ms - last_reg;

    // The state registers double as the result register
    always_comb
    begin
        out_status.remaining_ms = count_reg;
        out_status.running      = run_reg;
    end

    // Apply one request to the timer
    always_comb
    begin
        count_next = count_reg;
        run_next   = run_reg;
        last_next  = last_reg;
        unique case (in_timed.action)
            ACT_SET:
            begin
                count_next = in_timed.load_ms;
                run_next   = in_timed.start_now;
            end
            ACT_STOP:
            begin
                run_next = 1'b0;
            end
            ACT_RESTART:
            begin
                run_next = 1'b1;
            end
            ACT_UPDATE:
            begin
                // While running, count down only when time moved forward; store the time anyway
                if (run_reg)
                begin
                    if (in_timed.now_ms >= last_reg)
                    begin
                        count_next = (elapsed >= count_reg) ? '0 : count_reg - elapsed;
                    end
                    last_next = in_timed.now_ms;
                end
            end
        endcase
    end

    // Commit state on each taken request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            run_reg       <= 1'b0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
            if (take)
            begin
                count_reg <= count_next;
                run_reg   <= run_next;
                last_reg  <= last_next;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (take && (in_timed.action == ACT_STOP)) |=> !run_reg)
        else $error("stop request left the timer running");

    assert property (@(posedge clk) disable iff (!rst_n)
        (take && (in_timed.action == ACT_UPDATE)) |=> (count_reg <= $past(count_reg)))
        else $error("update request raised the count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (take && (in_timed.action == ACT_UPDATE) && !run_reg) |=> $stable(last_reg))
        else $error("update while stopped changed the stored time");

endmodule

`default_nettype wire

// ----- design/cdt_digits.sv -----
`default_nettype none

module cdt_digits
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire cdt_pkg::status_t  in_status,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output cdt_pkg::result_t       out_result
);
    import cdt_pkg::*;

    // Rounded-up reciprocals, exact over the value ranges they see
    localparam int unsigned SEC_SHIFT = 35;
    localparam logic [63:0] SEC_RECIP = ((64'd1 << SEC_SHIFT) + 64'd124) / 64'd125;
    localparam int unsigned HR_SHIFT  = 26;
    localparam logic [63:0] HR_RECIP  = ((64'd1 << HR_SHIFT) + 64'd224) / 64'd225;
    localparam int unsigned MIN_SHIFT = 18;
    localparam logic [63:0] MIN_RECIP = ((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60;

    // Quotient by ten for values below 1000
    function automatic logic [6:0] div10(input logic [9:0] x);
        logic [17:0] p;
        p = 18'(x) * 18'd205;
        return p[17:11];
    endfunction

    function automatic logic [3:0] mod10(input logic [9:0] x);
        logic [9:0] r;
        r = x - 10'(div10(x)) * 10'd10;
        return r[3:0];
    endfunction

    logic [4:0]  valid_reg;
    logic [5:0]  stage_ready;

    status_t     s1_stat_reg;
    logic [21:0] s1_sec_reg;
    status_t     s2_stat_reg;
    logic [11:0] s2_sec_lo_reg;
    logic [9:0]  s2_ms_reg;
    logic [9:0]  s2_hr_reg;
    result_t     s3_res_reg;
    logic [11:0] s3_rs_reg;
    result_t     s4_res_reg;
    logic [11:0] s4_rs_reg;
    logic [5:0]  s4_mn_reg;
    result_t     s5_res_reg;

    logic [56:0] sec_prod;
    logic [36:0] hr_prod;
    logic [9:0]  ms_next;
    logic [6:0]  ms_q;
    logic [6:0]  ms_qq;
    logic [6:0]  hr_q;
    logic [11:0] rs_next;
    result_t     s3_res_next;
    logic [24:0] mn_prod;
    logic [5:0]  ss;
    logic [6:0]  mn_q;
    logic [6:0]  ss_q;
    result_t     s5_res_next;

    // Ready chain, last stage first
    always_comb
    begin
        stage_ready[5] = out_ready;
        stage_ready[4] = !valid_reg[4] || stage_ready[5];
        stage_ready[3] = !valid_reg[3] || stage_ready[4];
        stage_ready[2] = !valid_reg[2] || stage_ready[3];
        stage_ready[1] = !valid_reg[1] || stage_ready[2];
        stage_ready[0] = !valid_reg[0] || stage_ready[1];
    end

    assign in_ready   = stage_ready[0];
    assign out_valid  = valid_reg[4];
    assign out_result = s5_res_reg;

    // Whole seconds: count / 8 / 125
    assign sec_prod = 57'(in_status.remaining_ms[30:3]) * SEC_RECIP[28:0];

    // Millisecond part and whole hours: seconds / 16 / 225
    assign ms_next = s1_stat_reg.remaining_ms[9:0] - s1_sec_reg[9:0] * 10'd1000;
    assign hr_prod = 37'(s1_sec_reg[21:4]) * HR_RECIP[18:0];

    // Seconds within the hour, sub-second and hour digits
    always_comb
    begin
        rs_next = s2_sec_lo_reg - s2_hr_reg * 12'd3600;
        ms_q    = div10(s2_ms_reg);
        ms_qq   = div10(10'(ms_q));
        hr_q    = div10(s2_hr_reg);

        s3_res_next                     = '0;
        s3_res_next.remaining_ms        = s2_stat_reg.remaining_ms;
        s3_res_next.running             = s2_stat_reg.running;
        s3_res_next.ms_units_digit      = mod10(s2_ms_reg);
        s3_res_next.hundredths_digit    = mod10(10'(ms_q));
        s3_res_next.tenths_digit        = ms_qq[3:0];
        s3_res_next.hours_units_digit   = mod10(s2_hr_reg);
        s3_res_next.hours_tens_digit    = mod10(10'(hr_q));
    end

    // Minutes within the hour
    assign mn_prod = 25'(s3_rs_reg) * MIN_RECIP[12:0];

    // Minute and second digits
    always_comb
    begin
        ss   = s4_rs_reg[5:0] - s4_mn_reg * 6'd60;
        mn_q = div10(10'(s4_mn_reg));
        ss_q = div10(10'(ss));

        s5_res_next                     = s4_res_reg;
        s5_res_next.seconds_units_digit = mod10(10'(ss));
        s5_res_next.seconds_tens_digit  = ss_q[2:0];
        s5_res_next.minutes_units_digit = mod10(10'(s4_mn_reg));
        s5_res_next.minutes_tens_digit  = mn_q[2:0];
    end

    // Advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (stage_ready[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (stage_ready[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
            if (stage_ready[3])
            begin
                valid_reg[3] <= valid_reg[2];
            end
            if (stage_ready[4])
            begin
                valid_reg[4] <= valid_reg[3];
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            s1_stat_reg <= in_status;
            s1_sec_reg  <= sec_prod[SEC_SHIFT +: 22];
        end
        if (stage_ready[1])
        begin
            s2_stat_reg   <= s1_stat_reg;
            s2_sec_lo_reg <= s1_sec_reg[11:0];
            s2_ms_reg     <= ms_next;
            s2_hr_reg     <= hr_prod[HR_SHIFT +: 10];
        end
        if (stage_ready[2])
        begin
            s3_res_reg <= s3_res_next;
            s3_rs_reg  <= rs_next;
        end
        if (stage_ready[3])
        begin
            s4_res_reg <= s3_res_reg;
            s4_rs_reg  <= s3_rs_reg;
            s4_mn_reg  <= mn_prod[MIN_SHIFT +: 6];
        end
        if (stage_ready[4])
        begin
            s5_res_reg <= s5_res_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[4] |-> ((s5_res_reg.seconds_tens_digit <= 3'd5)
                          && (s5_res_reg.minutes_tens_digit <= 3'd5)
                          && (s5_res_reg.ms_units_digit <= 4'd9)
                          && (s5_res_reg.tenths_digit <= 4'd9)
                          && (s5_res_reg.hours_tens_digit <= 4'd9)))
        else $error("digit out of range in readout");

endmodule

`default_nettype wire

// ----- design/countdown_timer_digits.sv -----
// Throughput: one request per cycle while m_tready does not hold the pipeline back; the
// count update in the state stage (compare, subtract, saturate) sets that rate.
// Every stage has its own ready, so an empty stage keeps taking requests
// while a finished result waits on m_tready.
// Reset (rst_n low, asynchronous): count, run flag, stored time and all valid flags clear.
`default_nettype none

module countdown_timer_digits
#(
    parameter int unsigned TICK_RATE = cdt_pkg::TICK_RATE_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [55:0]  s_tdata,   // load_ms[30:0], start_now[31], game_tick[53:32]
    input  wire logic [1:0]   s_tuser,   // action[1:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [71:0]       m_tdata    // remaining_ms[30:0], running[31],
                                         // ms_units_digit[35:32], hundredths_digit[39:36],
                                         // tenths_digit[43:40], seconds_units_digit[47:44],
                                         // seconds_tens_digit[50:48],
                                         // minutes_units_digit[54:51],
                                         // minutes_tens_digit[57:55],
                                         // hours_units_digit[61:58], hours_tens_digit[65:62]
);
    import cdt_pkg::*;

    req_t     req;
    timed_t   timed;
    status_t  status;
    result_t  result;
    logic     timed_valid;
    logic     timed_ready;
    logic     status_valid;
    logic     status_ready;

    // Unpack the request
    always_comb
    begin
        req.action     = action_t'(s_tuser);
        req.load_ms    = s_tdata[30:0];
        req.start_now  = s_tdata[31];
        req.game_tick  = s_tdata[53:32];
    end

    cdt_conv
    #(
        .TICK_RATE (TICK_RATE)
    )
    u_conv
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (req),
        .out_valid (timed_valid),
        .out_ready (timed_ready),
        .out_timed (timed)
    );

    cdt_state u_state
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (timed_valid),
        .in_ready   (timed_ready),
        .in_timed   (timed),
        .out_valid  (status_valid),
        .out_ready  (status_ready),
        .out_status (status)
    );

    cdt_digits u_digits
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (status_valid),
        .in_ready   (status_ready),
        .in_status  (status),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Pack the readout
    assign m_tdata = {6'd0,
                      result.hours_tens_digit,
                      result.hours_units_digit,
                      result.minutes_tens_digit,
                      result.minutes_units_digit,
                      result.seconds_tens_digit,
                      result.seconds_units_digit,
                      result.tenths_digit,
                      result.hundredths_digit,
                      result.ms_units_digit,
                      result.running,
                      result.remaining_ms};

endmodule

`default_nettype wire

// ----- tb/timer_readout_monitor.sv -----
module timer_readout_monitor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import cdt_pkg::*;

    // Timer state as the block should hold it
    logic [MS_W-1:0] model_count   = '0;
    logic            model_running = 1'b0;
    logic [MS_W-1:0] model_last_ms = '0;

    result_t expected_readouts[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // Convert a tick count to milliseconds, clamped to the count width
    function automatic logic [MS_W-1:0] ticks_to_ms(logic [TICK_W-1:0] ticks);
        logic [63:0] ms;
        ms = (64'(ticks) * 64'd1000) / 64'(TICK_RATE_DEF);
        if (ms > 64'(MS_MAX))
            ms = 64'(MS_MAX);
        return ms[MS_W-1:0];
    endfunction

    // Apply one request to the timer state and build the readout it causes
    function automatic result_t predict_readout(action_t act, logic [MS_W-1:0] load,
                                                logic auto_go, logic [TICK_W-1:0] ticks);
        result_t         r;
        logic [MS_W-1:0] now_ms;
        logic [MS_W-1:0] elapsed;
        logic [31:0]     c;
        case (act)
            ACT_SET:
            begin
                model_count   = load;
                model_running = auto_go;
            end
            ACT_STOP:    model_running = 1'b0;
            ACT_RESTART: model_running = 1'b1;
            default:
            begin
                if (model_running)
                begin
                    now_ms = ticks_to_ms(ticks);
                    // Time running backwards leaves the count alone
                    if (now_ms >= model_last_ms)
                    begin
                        elapsed     = now_ms - model_last_ms;
                        model_count = (elapsed >= model_count) ? '0 : model_count - elapsed;
                    end
                    model_last_ms = now_ms;
                end
            end
        endcase
        c = 32'(model_count);
        r.remaining_ms        = model_count;
        r.running             = model_running;
        r.ms_units_digit      = 4'(c % 10);
        r.hundredths_digit    = 4'((c / 10) % 10);
        r.tenths_digit        = 4'((c / 100) % 10);
        r.seconds_units_digit = 4'((c / 1000) % 10);
        r.seconds_tens_digit  = 3'((c / 10000) % 6);
        r.minutes_units_digit = 4'((c / 60000) % 10);
        r.minutes_tens_digit  = 3'((c / 600000) % 6);
        r.hours_units_digit   = 4'((c / 3600000) % 10);
        r.hours_tens_digit    = 4'((c / 36000000) % 10);
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Predict on each accepted request, compare on each accepted readout
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_readouts.push_back(predict_readout(action_t'(s_tuser),
                    s_tdata[30:0], s_tdata[31], s_tdata[53:32]));
            if (m_tvalid && m_tready)
            begin
                if (expected_readouts.size() == 0)
                begin
                    $error("readout with no request waiting");
                    fail_count++;
                end
                else
                begin
                    want = expected_readouts.pop_front();
                    check_field("remaining_ms", want.remaining_ms, m_tdata[30:0]);
                    check_field("running", want.running, m_tdata[31]);
                    check_field("ms_units_digit", want.ms_units_digit, m_tdata[35:32]);
                    check_field("hundredths_digit", want.hundredths_digit, m_tdata[39:36]);
                    check_field("tenths_digit", want.tenths_digit, m_tdata[43:40]);
                    check_field("seconds_units_digit", want.seconds_units_digit,
                                m_tdata[47:44]);
                    check_field("seconds_tens_digit", want.seconds_tens_digit,
                                m_tdata[50:48]);
                    check_field("minutes_units_digit", want.minutes_units_digit,
                                m_tdata[54:51]);
                    check_field("minutes_tens_digit", want.minutes_tens_digit,
                                m_tdata[57:55]);
                    check_field("hours_units_digit", want.hours_units_digit,
                                m_tdata[61:58]);
                    check_field("hours_tens_digit", want.hours_tens_digit, m_tdata[65:62]);
                end
            end
            pending = expected_readouts.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cdt_pkg::*;

    localparam int RANDOM_REQS = 950;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 200;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = ACT_SET;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    int fail_count;
    int pending;
    int stall_cycles = 0;

    // Idling off for a stretch, and a one-shot long hold on the readout side
    bit calm     = 1'b0;
    bit hold_req = 1'b0;

    countdown_timer_digits DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    timer_readout_monitor readout_mon
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Offer one request and hold it until accepted, then maybe idle
    task automatic send_req(action_t act, logic [MS_W-1:0] load, logic auto_go,
                            logic [TICK_W-1:0] ticks);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {2'b00, ticks, auto_go, load};
        do
            @(posedge clk);
        while (!s_tready);
        // Maybe idle: drop s_tvalid with odds of about 19 in a hundred, drawn anew each time
        while (!calm && $urandom_range(99) < 19)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Readout side: random backpressure, plus the long hold when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 19);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        logic [TICK_W-1:0] tick_now;
        logic [MS_W-1:0]   load;
        logic              auto_go;
        logic [TICK_W-1:0] ticks;
        action_t           act;
        int                pick;

        tick_now = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: stopped update, extremes, backwards time, stale time, underflow
        send_req(ACT_UPDATE, '0, 1'b0, '0);
        send_req(ACT_SET, MS_MAX, 1'b0, '1);
        send_req(ACT_SET, '0, 1'b1, '0);
        send_req(ACT_UPDATE, '0, 1'b0, '0);
        send_req(ACT_UPDATE, '1, 1'b1, '1);
        send_req(ACT_SET, MS_MAX, 1'b1, '0);
        send_req(ACT_UPDATE, '0, 1'b0, '0);
        send_req(ACT_UPDATE, '0, 1'b0, 22'd30);
        send_req(ACT_UPDATE, '0, 1'b0, 22'd3);
        send_req(ACT_STOP, '1, 1'b1, '1);
        send_req(ACT_UPDATE, '1, 1'b1, '1);
        send_req(ACT_RESTART, '1, 1'b0, '1);
        send_req(ACT_UPDATE, '0, 1'b0, 22'd60);
        send_req(ACT_SET, 31'd99999999, 1'b0, '0);
        send_req(ACT_RESTART, '0, 1'b0, '0);
        send_req(ACT_UPDATE, '0, 1'b0, 22'd61);
        send_req(ACT_SET, 31'd359999999, 1'b1, '0);
        send_req(ACT_UPDATE, '0, 1'b0, '1);
        send_req(ACT_SET, 31'd1, 1'b1, '0);
        send_req(ACT_UPDATE, '0, 1'b0, '1);
        send_req(ACT_UPDATE, '0, 1'b0, '0);
        send_req(ACT_UPDATE, '0, 1'b0, 22'd1);
        send_req(ACT_SET, 31'd12345678, 1'b0, '0);
        send_req(ACT_STOP, '0, 1'b0, '0);

        // Random: mostly running updates on an advancing tick count
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            if (i == 300)
                hold_req = 1'b1;
            calm    = (i >= 500 && i < 650);
            load    = MS_W'($urandom);
            auto_go = 1'($urandom_range(1));
            ticks   = TICK_W'($urandom);
            pick    = $urandom_range(99);
            if (pick < 62)
            begin
                act  = ACT_UPDATE;
                pick = $urandom_range(99);
                if (pick < 80)
                    tick_now = tick_now + TICK_W'($urandom_range(0, 90));
                else if (pick < 88)
                    tick_now = tick_now - TICK_W'($urandom_range(0, 50));
                else if (pick < 95)
                    tick_now = tick_now + TICK_W'($urandom_range(0, 5000));
                else
                    tick_now = TICK_W'($urandom);
                ticks = tick_now;
            end
            else if (pick < 78)
            begin
                act     = ACT_SET;
                auto_go = ($urandom_range(99) < 75);
                case ($urandom_range(7))
                    0: load = '0;
                    1: load = MS_MAX;
                    2: load = MS_W'($urandom_range(1, 200));
                    3, 4: load = MS_W'($urandom_range(1000, 600000));
                    5: load = MS_W'($urandom_range(600000, 360000000));
                    6: load = MS_W'($urandom);
                    default: load = MS_W'($urandom_range(3590000, 3610000));
                endcase
            end
            else if (pick < 88)
                act = ACT_RESTART;
            else
                act = ACT_STOP;
            send_req(act, load, auto_go, ticks);
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;
        @(posedge clk);

        // Drain outstanding readouts, then allow for pipeline latency
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
design/cdt_pkg.sv
design/cdt_conv.sv
design/cdt_state.sv
design/cdt_digits.sv
design/countdown_timer_digits.sv
tb/timer_readout_monitor.sv
tb/tb_top.sv
